/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers shared by the RTL, clocked on clk.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Held off while rst_n is low.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Also checked during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/bcdc_pkg.sv */
// ----------------------------------------------------------------------------
// bcdc_pkg
// Shared constants, types and the double-dabble step for the BCD converter.
// ----------------------------------------------------------------------------
package bcdc_pkg;

  localparam int MAX_DIGITS_DEF = 8;
  localparam int BCD_DIGITS     = 8;
  localparam int BCD_W          = 4 * BCD_DIGITS;
  localparam int BIN_W          = 27;   // holds 99999999
  localparam int ACC_W          = 27;
  localparam logic [31:0] BIN_LIMIT = 32'd99999999;

  typedef logic [1:0] status_t;

  localparam status_t STAT_OK       = 2'd0;
  localparam status_t STAT_TOO_MANY = 2'd1;
  localparam status_t STAT_BAD_NIB  = 2'd2;
  localparam status_t STAT_RANGE    = 2'd3;

  typedef struct packed {
    logic done;   // one-cycle pulse, result held until next start
    logic bad;    // invalid nibble seen
  } unit_stat_t;

  // One double-dabble step: correct each digit, then shift in one bit.
  function automatic logic [BCD_W-1:0] dd_step(input logic [BCD_W-1:0] bcd,
                                               input logic b);
    logic [BCD_W-1:0] adj;
    for (int i = 0; i < BCD_DIGITS; i++) begin
      adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3 : bcd[4*i +: 4];
    end
    return {adj[BCD_W-2:0], b};
  endfunction

endpackage

/* rtl/bcdc_bcd2bin.sv */
// ----------------------------------------------------------------------------
// bcdc_bcd2bin
// Packed BCD to binary, one nibble per cycle, most significant digit first.
// ----------------------------------------------------------------------------
module bcdc_bcd2bin #(
  parameter int MAX_DIGITS = bcdc_pkg::MAX_DIGITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [31:0]              word,
  input  logic [3:0]               count,
  output bcdc_pkg::unit_stat_t     stat,
  output logic [31:0]              value
);

  localparam int SH_W  = 4 * MAX_DIGITS;
  localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  logic [SH_W-1:0]            sh_r, sh_nxt;
  logic [bcdc_pkg::ACC_W-1:0] acc_r, acc_nxt;
  logic [IDX_W-1:0]           idx_r, idx_nxt;
  logic [3:0]                 count_r;
  logic                       bad_r, bad_nxt;
  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic                       use_nib;
  logic [3:0]                 nib;

  always_comb begin
    use_nib  = 4'(idx_r) < count_r;
    nib      = use_nib ? sh_r[SH_W-1 -: 4] : 4'd0;
    sh_nxt   = sh_r;
    acc_nxt  = acc_r;
    idx_nxt  = idx_r;
    bad_nxt  = bad_r;
    busy_nxt = busy_r;
    done_nxt = busy_r && (idx_r == '0);
    if (start) begin
      sh_nxt   = word[SH_W-1:0];
      acc_nxt  = '0;
      idx_nxt  = IDX_W'(MAX_DIGITS - 1);
      bad_nxt  = 1'b0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // acc*10 + digit; leading digits past the count enter as zero
      sh_nxt  = sh_r << 4;
      acc_nxt = bcdc_pkg::ACC_W'({acc_r, 3'b000}) + bcdc_pkg::ACC_W'({acc_r, 1'b0})
                + bcdc_pkg::ACC_W'(nib);
      bad_nxt = bad_r || (nib > 4'd9);
      if (idx_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r  <= sh_nxt;
    acc_r <= acc_nxt;
    idx_r <= idx_nxt;
    bad_r <= bad_nxt;
    if (start) begin
      count_r <= count;
    end
  end

  assign stat.done = done_r;
  assign stat.bad  = bad_r;
  assign value     = 32'(acc_r);

endmodule

/* rtl/bcdc_bin2bcd.sv */
// ----------------------------------------------------------------------------
// bcdc_bin2bcd
// Binary to packed BCD by double dabble, three bits per cycle.
// ----------------------------------------------------------------------------
module bcdc_bin2bcd (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [bcdc_pkg::BIN_W-1:0]    value,
  input  logic [3:0]                    count,
  output bcdc_pkg::unit_stat_t          stat,
  output logic [31:0]                   bcd
);

  localparam int BW    = bcdc_pkg::BIN_W;
  localparam int STEPS = BW / 3;
  localparam int CNT_W = $clog2(STEPS);

  logic [BW-1:0]              bin_r, bin_nxt;
  logic [bcdc_pkg::BCD_W-1:0] bcd_r, bcd_nxt;
  logic [bcdc_pkg::BCD_W-1:0] s1, s2, s3;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic [3:0]                 count_r;
  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;

  always_comb begin
    s1 = bcdc_pkg::dd_step(bcd_r, bin_r[BW-1]);
    s2 = bcdc_pkg::dd_step(s1,    bin_r[BW-2]);
    s3 = bcdc_pkg::dd_step(s2,    bin_r[BW-3]);
    bin_nxt  = bin_r;
    bcd_nxt  = bcd_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = busy_r && (cnt_r == '0);
    if (start) begin
      bin_nxt  = value;
      bcd_nxt  = '0;
      cnt_nxt  = CNT_W'(STEPS - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      bin_nxt = bin_r << 3;
      bcd_nxt = s3;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
    cnt_r <= cnt_nxt;
    if (start) begin
      count_r <= count;
    end
  end

  // keep only the lowest count digits
  always_comb begin
    for (int i = 0; i < bcdc_pkg::BCD_DIGITS; i++) begin
      bcd[4*i +: 4] = (4'(i) < count_r) ? bcd_r[4*i +: 4] : 4'd0;
    end
  end

  assign stat.done = done_r;
  assign stat.bad  = 1'b0;

endmodule

/* rtl/bcd_binary_converter_top.sv */
// BCD to binary converts one nibble per cycle; binary to BCD runs nine 3-bit double-dabble
//   steps. One word is converted at a time: in_ready drops while a word converts.
// The output register frees the input side once a result is stored.
// Reset: synchronous, active low; clears control state, no word pending.
// ----------------------------------------------------------------------------
// bcd_binary_converter_top
// Packed BCD <-> binary converter, one word in, one word out.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bcd_binary_converter_top #(
  parameter int MAX_DIGITS = bcdc_pkg::MAX_DIGITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_action,
  input  logic [31:0]             in_operand,
  input  logic [3:0]              in_digit_count,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [31:0]             out_converted,
  output logic [1:0]              out_status
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;

  logic [1:0]              state_r, state_nxt;
  logic                    action_r;
  bcdc_pkg::status_t       pre_st_r, pre_st;
  logic                    out_valid_r, out_valid_nxt;
  logic [31:0]             out_converted_r;
  bcdc_pkg::status_t       out_status_r;

  logic                    accept, out_free, load;
  bcdc_pkg::unit_stat_t    b2b_stat, bb_stat, sel_stat;
  logic [31:0]             b2b_value, bb_value, sel_value;
  bcdc_pkg::status_t       res_status;
  logic [31:0]             res_value;

  bcdc_bcd2bin #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_bcd2bin (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept),
    .word  (in_operand),
    .count (in_digit_count),
    .stat  (b2b_stat),
    .value (b2b_value)
  );

  bcdc_bin2bcd u_bin2bcd (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept),
    .value (in_operand[bcdc_pkg::BIN_W-1:0]),
    .count (in_digit_count),
    .stat  (bb_stat),
    .bcd   (bb_value)
  );

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // checks decided at the input; digit count is checked first
  always_comb begin
    if (in_digit_count > 4'(MAX_DIGITS)) begin
      pre_st = bcdc_pkg::STAT_TOO_MANY;
    end else if (in_action && (in_operand > bcdc_pkg::BIN_LIMIT)) begin
      pre_st = bcdc_pkg::STAT_RANGE;
    end else begin
      pre_st = bcdc_pkg::STAT_OK;
    end
  end

  always_comb begin
    sel_stat  = action_r ? bb_stat  : b2b_stat;
    sel_value = action_r ? bb_value : b2b_value;
    if (pre_st_r != bcdc_pkg::STAT_OK) begin
      res_status = pre_st_r;
    end else if (sel_stat.bad) begin
      res_status = bcdc_pkg::STAT_BAD_NIB;
    end else begin
      res_status = bcdc_pkg::STAT_OK;
    end
    res_value = (res_status == bcdc_pkg::STAT_OK) ? sel_value : 32'd0;
  end

  always_comb begin
    state_nxt = state_r;
    load      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (sel_stat.done) begin
          if (out_free) begin
            load      = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_WAIT;
          end
        end
      end
      ST_WAIT: begin
        // unit holds its result until the next start
        if (out_free) begin
          load      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      action_r <= in_action;
      pre_st_r <= pre_st;
    end
    if (load) begin
      out_converted_r <= res_value;
      out_status_r    <= res_status;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_converted = out_converted_r;
  assign out_status    = out_status_r;

  `ASSERT_CLK(a_fail_zero,
    out_valid_r && (out_status_r != bcdc_pkg::STAT_OK) |-> out_converted_r == 32'd0,
    "failed conversion with non-zero result")
  `ASSERT_CLK(a_accept_run, accept |=> state_r == ST_RUN,
    "accepted word did not start conversion")
  `ASSERT_CLK(a_done_in_run, sel_stat.done |-> state_r == ST_RUN,
    "unit finished while no conversion pending")
  `ASSERT_CLK(a_load_from_work, $rose(out_valid_r) |-> $past(state_r) != ST_IDLE,
    "result appeared without a conversion")

endmodule
